// ===== design/huber_stencil_penalty_top_assert.svh =====
// assertion macros used by the huber stencil penalty controller
`ifndef HUBER_STENCIL_PENALTY_TOP_ASSERT_SVH
`define HUBER_STENCIL_PENALTY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HSP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsp assertion failed");
`define HSP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsp assertion failed");
`else
`define HSP_ASSERT_IMP(label, ante, cons)
`define HSP_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== design/hsp_pkg.sv =====
// types, constants and control structs of the huber stencil penalty block
`default_nettype none
package hsp_pkg;

    localparam int PIXEL_BITS      = 16;
    localparam int HSP_MAX_COLUMNS = 1024;
    localparam int COLS_BITS       = 11;
    localparam int CFG_BITS        = 16;
    localparam int PEN_BITS        = 40;
    localparam int SUM_BITS        = PIXEL_BITS + 2;
    localparam int PROD_BITS       = 2 * SUM_BITS;
    localparam int V_BITS          = PROD_BITS + 1;
    localparam int V_LO_BITS       = 21;
    localparam int SCALE_SHIFT     = 13;

    localparam logic [COLS_BITS-1:0] RST_COLUMNS = COLS_BITS'(1024);
    localparam logic [CFG_BITS-1:0]  RST_ROWS    = CFG_BITS'(1024);
    localparam logic [CFG_BITS-1:0]  RST_TAU     = CFG_BITS'(256);
    localparam logic [CFG_BITS-1:0]  RST_SIGMA   = CFG_BITS'(256);

    typedef enum logic [1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_TAU     = 2'd2,
        CFG_SIGMA   = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_SPLIT,
        S_SUM
    } t_state;

    typedef struct packed {
        logic accept;
        logic stage_read;
        logic stage_mul;
        logic stage_split;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
    } t_status;

endpackage
`default_nettype wire

// ===== design/hsp_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none
module hsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/hsp_datapath.sv =====
// line store, window, counters, huber arithmetic and result register
`default_nettype none
module hsp_datapath import hsp_pkg::*; #(
    parameter int MAX_COLUMNS = HSP_MAX_COLUMNS
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [1:0]                   i_cfg_index,
    input  wire [CFG_BITS-1:0]          i_cfg_data,
    input  wire signed [PIXEL_BITS-1:0] i_pixel,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    output logic [PEN_BITS-1:0]         o_penalty,
    output logic                        o_last_of_image
);

    localparam int CW   = $clog2(MAX_COLUMNS);
    localparam int HW   = $clog2(MAX_COLUMNS + 1);
    localparam int CMPW = (HW > COLS_BITS ? HW : COLS_BITS) + 1;
    localparam int SW   = V_BITS + CFG_BITS;

    logic [COLS_BITS-1:0] r_cols;
    logic [CFG_BITS-1:0]  r_rows, r_tau, r_sigma;
    logic [CW-1:0]        r_col, n_col, r_addr;
    logic [CFG_BITS-1:0]  r_row, n_row;
    logic [HW-1:0]        r_hw;
    logic                 r_fresh, r_emit, r_last;
    logic [PIXEL_BITS-1:0] r_px, r_win_a, r_win_b, r_above, r_below;
    logic [SUM_BITS-1:0]  r_mag;
    logic                 r_big;
    logic [PROD_BITS-1:0] r_prod;
    logic [V_LO_BITS+CFG_BITS-1:0] r_plo;
    logic [2*CFG_BITS-1:0] r_phi;

    logic [CMPW-1:0]      cols_ext, cols_eff, col_next;
    logic [CFG_BITS-1:0]  rows_eff;
    logic                 row_end, img_end;
    logic [2*PIXEL_BITS-1:0] rd_data;
    logic [PIXEL_BITS-1:0] up1, up2;
    logic signed [SUM_BITS-1:0] s_sum;
    logic [SUM_BITS-1:0]  mag;
    logic [SUM_BITS-1:0]  mul_a, mul_b;
    logic [V_BITS-1:0]    v_val;
    logic [SW-1:0]        scaled;

    // geometry clamps and row / image end
    always_comb begin
        cols_ext = CMPW'(r_cols);
        if (cols_ext < CMPW'(3)) begin
            cols_eff = CMPW'(3);
        end else if (cols_ext > CMPW'(MAX_COLUMNS)) begin
            cols_eff = CMPW'(MAX_COLUMNS);
        end else begin
            cols_eff = cols_ext;
        end
        rows_eff = (r_rows < CFG_BITS'(3)) ? CFG_BITS'(3) : r_rows;
        col_next = CMPW'(r_col) + CMPW'(1);
        row_end  = (col_next >= cols_eff);
        img_end  = row_end && (({1'b0, r_row} + 17'd1) >= {1'b0, rows_eff});
        if (img_end) begin
            n_col = '0;
            n_row = '0;
        end else if (row_end) begin
            n_col = '0;
            n_row = r_row + CFG_BITS'(1);
        end else begin
            n_col = CW'(col_next);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= RST_COLUMNS;
            r_rows  <= RST_ROWS;
            r_tau   <= RST_TAU;
            r_sigma <= RST_SIGMA;
            r_col   <= '0;
            r_row   <= '0;
            r_hw    <= '0;
            r_emit  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_COLUMNS: r_cols  <= i_cfg_data[COLS_BITS-1:0];
                    CFG_ROWS:    r_rows  <= i_cfg_data;
                    CFG_TAU:     r_tau   <= i_cfg_data;
                    CFG_SIGMA:   r_sigma <= i_cfg_data;
                endcase
            end
            if (i_cmd.accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_emit <= (r_row >= CFG_BITS'(2)) && (r_col >= CW'(2));
                // columns below the fill mark hold written data
                if (HW'(r_col) == r_hw) begin
                    r_hw <= r_hw + HW'(1);
                end
            end
        end
    end

    hsp_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.stage_read),
        .i_waddr (r_addr),
        .i_wdata ({up1, r_px}),
        .i_re    (i_cmd.accept),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    always_comb begin
        up1   = r_fresh ? rd_data[PIXEL_BITS-1:0] : '0;
        up2   = r_fresh ? rd_data[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
        s_sum = $signed({{2{r_below[PIXEL_BITS-1]}}, r_below})
              - $signed({{2{r_above[PIXEL_BITS-1]}}, r_above})
              + $signed({{2{up1[PIXEL_BITS-1]}}, up1})
              - $signed({{2{r_win_a[PIXEL_BITS-1]}}, r_win_a});
        mag   = s_sum[SUM_BITS-1] ? SUM_BITS'(-s_sum) : SUM_BITS'(s_sum);
        mul_a = r_big ? SUM_BITS'(r_tau) : r_mag;
        mul_b = r_big ? (r_mag - SUM_BITS'({r_tau, 1'b0})) : r_mag;
        v_val = r_big ? {r_prod[PROD_BITS-3:0], 3'b000} : {1'b0, r_prod};
        scaled = {r_phi, {V_LO_BITS{1'b0}}} + SW'(r_plo);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px    <= i_pixel;
            r_addr  <= r_col;
            r_fresh <= (HW'(r_col) < r_hw);
            r_last  <= img_end;
        end
        if (i_cmd.stage_read) begin
            r_win_a <= r_win_b;
            r_win_b <= up1;
            r_above <= up2;
            r_below <= r_px;
            r_mag   <= mag;
            r_big   <= (mag >= SUM_BITS'({r_tau, 2'b00}));
        end
        if (i_cmd.stage_mul) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.stage_split) begin
            r_plo <= v_val[V_LO_BITS-1:0] * r_sigma;
            r_phi <= v_val[V_BITS-1:V_LO_BITS] * r_sigma;
        end
        if (i_cmd.load_out) begin
            o_penalty       <= scaled[SCALE_SHIFT+PEN_BITS-1:SCALE_SHIFT];
            o_last_of_image <= r_last;
        end
    end

    assign o_status.emit = r_emit;

endmodule
`default_nettype wire

// ===== design/hsp_ctrl.sv =====
// controller state machine and output beat handshake
`default_nettype none
`include "huber_stencil_penalty_top_assert.svh"
module hsp_ctrl import hsp_pkg::*; (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  wire     i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   accept, out_taken, load;

    always_comb begin
        accept    = (r_state == S_IDLE) && i_valid;
        out_taken = r_out_valid && !i_stall;
        load      = (r_state == S_SUM) && (!r_out_valid || out_taken);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) begin
                n_state = S_READ;
            end
            S_READ:  n_state = i_status.emit ? S_MUL : S_IDLE;
            S_MUL:   n_state = S_SPLIT;
            S_SPLIT: n_state = S_SUM;
            S_SUM:   if (load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall           = (r_state != S_IDLE);
        o_cmd.accept      = accept;
        o_cmd.stage_read  = (r_state == S_READ);
        o_cmd.stage_mul   = (r_state == S_MUL);
        o_cmd.stage_split = (r_state == S_SPLIT);
        o_cmd.load_out    = load;
        o_valid           = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `HSP_ASSERT_NXT(a_accept_reads, accept, r_state == S_READ)
    `HSP_ASSERT_NXT(a_border_returns, (r_state == S_READ) && !i_status.emit, r_state == S_IDLE)
    `HSP_ASSERT_NXT(a_blocked_holds, (r_state == S_SUM) && r_out_valid && i_stall, r_state == S_SUM)
    `HSP_ASSERT_NXT(a_load_shows, load, r_out_valid)
    `HSP_ASSERT_IMP(a_busy_stalls, r_state != S_IDLE, o_stall)

endmodule
`default_nettype wire

// ===== design/huber_stencil_penalty_top.sv =====
// Huber total-variation penalty over a raster pixel stream. Pixels enter one per beat, row
// by row; each interior pixel yields one scaled Huber value of its stencil gradient, border
// pixels yield none, and o_last_of_image marks the final interior pixel of the image. A
// border pixel occupies the block for accept and the line-store read and write back; an
// interior pixel goes on through one 18x18 multiplier stage, the split sigma multiply and
// the final sum, waiting there until the output register can load. The line store starts
// empty after reset: a fill mark stands in for clearing it, so there is no clearing pass.
// Write configuration only while the block is idle; the block itself does not enforce it.
`default_nettype none
module huber_stencil_penalty_top import hsp_pkg::*; #(
    parameter int MAX_COLUMNS = HSP_MAX_COLUMNS
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [1:0]                   i_cfg_index,
    input  wire [CFG_BITS-1:0]          i_cfg_data,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire signed [PIXEL_BITS-1:0] i_pixel,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [PEN_BITS-1:0]         o_penalty,
    output logic                        o_last_of_image
);

    t_cmd    cmd;
    t_status status;

    hsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hsp_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pixel         (i_pixel),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_penalty       (o_penalty),
        .o_last_of_image (o_last_of_image)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the huber stencil penalty block
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsp_pkg::*;

    localparam longint unsigned PEN_MAX = (64'd1 << PEN_BITS) - 64'd1;
    localparam int RANDOM_PIXELS = 1000;
    localparam int DRAIN_CYCLES  = 12;

    typedef struct {
        logic [PEN_BITS-1:0] penalty;
        logic                last;
    } t_penalty_beat;

    typedef enum int {
        PX_RANDOM,
        PX_SMALL,
        PX_EXTREME,
        PX_RAMP,
        PX_RIDGE_UP,
        PX_RIDGE_DOWN,
        PX_FLAT
    } t_px_mode;

    class t_penalty_scoreboard;
        logic [COLS_BITS-1:0]         reg_columns;
        logic [CFG_BITS-1:0]          reg_rows;
        logic [CFG_BITS-1:0]          reg_tau;
        logic [CFG_BITS-1:0]          reg_sigma;
        logic signed [PIXEL_BITS-1:0] line_mem [2*HSP_MAX_COLUMNS];
        logic signed [PIXEL_BITS-1:0] win [3];
        logic signed [PIXEL_BITS-1:0] above_px;
        logic signed [PIXEL_BITS-1:0] below_px;
        int unsigned                  col_cnt;
        int unsigned                  row_cnt;
        t_penalty_beat                penalty_q [$];
        int                           errors;

        function new();
            reg_columns = RST_COLUMNS;
            reg_rows    = RST_ROWS;
            reg_tau     = RST_TAU;
            reg_sigma   = RST_SIGMA;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i]) win[i] = '0;
            above_px = '0;
            below_px = '0;
            col_cnt  = 0;
            row_cnt  = 0;
            errors   = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [CFG_BITS-1:0] data);
            case (idx)
                CFG_COLUMNS: reg_columns = data[COLS_BITS-1:0];
                CFG_ROWS:    reg_rows    = data;
                CFG_TAU:     reg_tau     = data;
                CFG_SIGMA:   reg_sigma   = data;
                default: ;
            endcase
        endfunction

        function int unsigned columns_used();
            int unsigned cols;
            cols = reg_columns;
            if (cols < 3) cols = 3;
            if (cols > HSP_MAX_COLUMNS) cols = HSP_MAX_COLUMNS;
            return cols;
        endfunction

        function int unsigned rows_used();
            return (reg_rows < 3) ? 3 : reg_rows;
        endfunction

        // sigma * huber(du, tau) in Q24.16, du = s / 4
        function logic [PEN_BITS-1:0] huber_penalty(longint s);
            longint unsigned a, t, sg, v;
            a  = (s < 0) ? -s : s;
            t  = reg_tau;
            sg = reg_sigma;
            if (a < 4 * t) v = a * a;
            else v = 8 * t * a - 16 * t * t;
            v = (v * sg) >> SCALE_SHIFT;
            if (v > PEN_MAX) v = PEN_MAX;
            return v[PEN_BITS-1:0];
        endfunction

        function void note_pixel(logic signed [PIXEL_BITS-1:0] px);
            int unsigned                  c, r;
            logic signed [PIXEL_BITS-1:0] up1, up2;
            bit                           row_end, img_end;
            longint                       s;
            t_penalty_beat                b;
            c = (col_cnt >= HSP_MAX_COLUMNS) ? HSP_MAX_COLUMNS - 1 : col_cnt;
            r = row_cnt;
            up1 = line_mem[c];
            up2 = line_mem[HSP_MAX_COLUMNS + c];
            line_mem[HSP_MAX_COLUMNS + c] = up1;
            line_mem[c] = px;
            win[0] = win[1];
            win[1] = win[2];
            win[2] = up1;
            row_end = (c + 1 >= columns_used());
            img_end = row_end && (r + 1 >= rows_used());
            if (r >= 2 && c >= 2) begin
                s = longint'(below_px) - longint'(above_px) + longint'(win[2]) - longint'(win[0]);
                b.penalty = huber_penalty(s);
                b.last    = img_end;
                penalty_q.push_back(b);
            end
            above_px = up2;
            below_px = px;
            if (img_end) begin
                col_cnt = 0;
                row_cnt = 0;
            end else if (row_end) begin
                col_cnt = 0;
                row_cnt = (r + 1) & 32'hFFFF;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void check_beat(logic [PEN_BITS-1:0] pen, logic last);
            t_penalty_beat b;
            if (penalty_q.size() == 0) begin
                $error("unexpected beat: penalty %0d last_of_image %0b", pen, last);
                errors++;
                return;
            end
            b = penalty_q.pop_front();
            if (pen !== b.penalty) begin
                $error("penalty: expected %0d, actual %0d", b.penalty, pen);
                errors++;
            end
            if (last !== b.last) begin
                $error("last_of_image: expected %0b, actual %0b", b.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return penalty_q.size();
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [1:0]                   i_cfg_index = '0;
    logic [CFG_BITS-1:0]          i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic signed [PIXEL_BITS-1:0] i_pixel = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic [PEN_BITS-1:0]          o_penalty;
    logic                         o_last_of_image;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    t_penalty_scoreboard sb = new();

    huber_stencil_penalty_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_penalty      (o_penalty),
        .o_last_of_image(o_last_of_image)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= rx_idle_on && ($urandom_range(99) < 23);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_beat(o_penalty, o_last_of_image);
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic signed [PIXEL_BITS-1:0] pick_pixel(t_px_mode m, int unsigned r,
                                                               int unsigned c);
        int  v;
        bit  hi;
        hi = (r % 3 == 2) || (c % 3 == 2);
        case (m)
            PX_RANDOM:     v = $urandom;
            PX_SMALL:      v = int'($urandom_range(0, 64)) - 32;
            PX_EXTREME:    v = $urandom_range(1) ? 32767 : -32768;
            PX_RAMP:       v = int'(r * 1201 + c * 379);
            PX_RIDGE_UP:   v = hi ? 32767 : -32768;
            PX_RIDGE_DOWN: v = hi ? -32768 : 32767;
            default:       v = 0;
        endcase
        return PIXEL_BITS'(v);
    endfunction

    // leaves the write enable high so back-to-back writes never toggle it within a step
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
        @(negedge i_clk);
    endtask

    task automatic write_geometry(input logic [CFG_BITS-1:0] cols,
                                  input logic [CFG_BITS-1:0] rows,
                                  input logic [CFG_BITS-1:0] tau,
                                  input logic [CFG_BITS-1:0] sigma);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_TAU, tau);
        write_reg(CFG_SIGMA, sigma);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(input logic signed [PIXEL_BITS-1:0] px);
        while (tx_idle_on && $urandom_range(99) < 23) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(px);
        @(negedge i_clk);
    endtask

    task automatic feed_pixels(input int unsigned count, input t_px_mode m);
        for (int unsigned k = 0; k < count; k++) begin
            push_pixel(pick_pixel(m, sb.row_cnt, sb.col_cnt));
        end
        i_valid <= 1'b0;
    endtask

    // border pixels give no beat, so allow the pipe to settle after the last one
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int unsigned random_count;
        int unsigned n;
        int unsigned area;
        int unsigned sel;
        logic [CFG_BITS-1:0] val;

        random_count = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: steepest gradient in the quadratic region, upper column bits ignored
        write_geometry(16'hF803, 16'd3, 16'hFFFF, 16'hFFFF);
        feed_pixels(9, PX_RIDGE_UP);
        drain();
        // clamped geometry, linear region with the smallest nonzero threshold
        write_geometry(16'd0, 16'd1, 16'd1, 16'hFFFF);
        feed_pixels(9, PX_RIDGE_DOWN);
        drain();
        // zero threshold and zero scale
        write_geometry(16'd2, 16'd0, 16'd0, 16'd0);
        feed_pixels(9, PX_EXTREME);
        drain();

        // widest rows clamp to the line store size, then the row is cut short mid-image
        write_geometry(16'hFFFF, 16'd3, 16'd256, 16'd256);
        feed_pixels(64, PX_RANDOM);
        drain();
        write_reg(CFG_COLUMNS, 16'd5);
        write_reg(CFG_ROWS, 16'hFFFF);
        i_cfg_we <= 1'b0;
        feed_pixels(40, PX_SMALL);
        drain();

        while (random_count < RANDOM_PIXELS) begin
            drain();
            tx_idle_on = ($urandom_range(4) != 0);
            rx_idle_on = tx_idle_on;
            if ($urandom_range(9) < 7) begin
                sel = $urandom_range(99);
                if (sel < 70) val = CFG_BITS'($urandom_range(3, 10));
                else if (sel < 80) val = CFG_BITS'($urandom_range(0, 2));
                else if (sel < 90) val = CFG_BITS'($urandom_range(11, 64));
                else val = CFG_BITS'($urandom);
                write_reg(CFG_COLUMNS, val);
            end
            if ($urandom_range(9) < 6) begin
                sel = $urandom_range(99);
                if (sel < 70) val = CFG_BITS'($urandom_range(3, 6));
                else if (sel < 80) val = CFG_BITS'($urandom_range(0, 2));
                else if (sel < 90) val = CFG_BITS'($urandom_range(7, 12));
                else val = $urandom_range(1) ? 16'hFFFF : CFG_BITS'($urandom);
                write_reg(CFG_ROWS, val);
            end
            if ($urandom_range(9) < 6) begin
                sel = $urandom_range(99);
                if (sel < 10) val = 16'd0;
                else if (sel < 20) val = 16'hFFFF;
                else if (sel < 50) val = CFG_BITS'($urandom_range(0, 64));
                else if (sel < 70) val = CFG_BITS'($urandom_range(256, 4096));
                else val = CFG_BITS'($urandom);
                write_reg(CFG_TAU, val);
            end
            if ($urandom_range(9) < 6) begin
                sel = $urandom_range(99);
                if (sel < 10) val = 16'd0;
                else if (sel < 20) val = 16'hFFFF;
                else if (sel < 40) val = 16'd256;
                else val = CFG_BITS'($urandom);
                write_reg(CFG_SIGMA, val);
            end
            i_cfg_we <= 1'b0;

            area = sb.columns_used() * sb.rows_used();
            if (area <= 300) n = area * $urandom_range(1, 3);
            else n = $urandom_range(20, 200);
            if (area <= 300 && $urandom_range(3) == 0) begin
                n += $urandom_range(1, 2 * sb.columns_used());
            end
            if (n > RANDOM_PIXELS - random_count) n = RANDOM_PIXELS - random_count;
            feed_pixels(n, t_px_mode'($urandom_range(0, 6)));
            random_count += n;
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
